@@ hdl/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the compacting record table: command and
// status codes, record layout and the control bundles between the FSM and
// the datapath.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 7;
    localparam int SEQ_W       = 7;
    localparam int KEY_LO_W    = 64;
    localparam int KEY_HI_W    = 16;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_DELETE = 2'd1;
    localparam t_cmd CMD_SEARCH = 2'd2;
    localparam t_cmd CMD_LIST   = 2'd3;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KEY_LO_W-1:0] first_low;
        logic [KEY_HI_W-1:0] first_high;
        logic [KEY_LO_W-1:0] surname_low;
        logic [KEY_HI_W-1:0] surname_high;
        logic [KEY_LO_W-1:0] phone_low;
        logic [KEY_HI_W-1:0] phone_high;
    } t_rec;

    typedef struct packed {
        t_status          status;
        logic [SEQ_W-1:0] seq_number;
        t_rec             rec;
        logic             last_of_run;
        logic [CNT_W-1:0] record_count;
    } t_rsp;

    // FSM to datapath
    typedef struct packed {
        logic    capture;
        logic    idx_inc;
        logic    mem_rd;
        logic    wr_add;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    pend_load;
        logic    pend_clr;
        logic    out_load;
        logic    out_pend;
        logic    out_last;
        t_status out_status;
    } t_dp_cmd;

    // datapath to FSM
    typedef struct packed {
        t_cmd cmd;
        logic idx_end;
        logic cnt_zero;
        logic cnt_full;
        logic hit;
        logic out_free;
        logic pend_valid;
    } t_dp_sts;

endpackage

@@ hdl/crt_in_if.sv @@
// ----------------------------------------------------------------------------
// crt_in_if
// Command channel: one word carries a command and the three keys.
// ----------------------------------------------------------------------------
interface crt_in_if import crt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_LO_W-1:0] first_low;
    logic [KEY_HI_W-1:0] first_high;
    logic [KEY_LO_W-1:0] surname_low;
    logic [KEY_HI_W-1:0] surname_high;
    logic [KEY_LO_W-1:0] phone_low;
    logic [KEY_HI_W-1:0] phone_high;

    modport source (
        output valid, cmd, first_low, first_high, surname_low, surname_high,
               phone_low, phone_high,
        input  ready
    );
    modport sink (
        input  valid, cmd, first_low, first_high, surname_low, surname_high,
               phone_low, phone_high,
        output ready
    );
endinterface

@@ hdl/crt_out_if.sv @@
// ----------------------------------------------------------------------------
// crt_out_if
// Result channel: one word per status or record given back.
// ----------------------------------------------------------------------------
interface crt_out_if import crt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq_number;
    logic [KEY_LO_W-1:0] out_first_low;
    logic [KEY_HI_W-1:0] out_first_high;
    logic [KEY_LO_W-1:0] out_surname_low;
    logic [KEY_HI_W-1:0] out_surname_high;
    logic [KEY_LO_W-1:0] out_phone_low;
    logic [KEY_HI_W-1:0] out_phone_high;
    logic                last_of_run;
    logic [CNT_W-1:0]    record_count;

    modport source (
        output valid, status, seq_number, out_first_low, out_first_high,
               out_surname_low, out_surname_high, out_phone_low,
               out_phone_high, last_of_run, record_count,
        input  ready
    );
    modport sink (
        input  valid, status, seq_number, out_first_low, out_first_high,
               out_surname_low, out_surname_high, out_phone_low,
               out_phone_high, last_of_run, record_count,
        output ready
    );
endinterface

@@ hdl/compacting_record_table.sv @@
// ----------------------------------------------------------------------------
// compacting_record_table
// Packed table of name and phone records with add, delete, search and list.
//
//   channel   dir  modport  carries
//   i_req     in   sink     cmd, first/surname/phone keys (one word per command)
//   o_rsp     out  source   status, seq_number, record, last_of_run, record_count
//
// Add, and any command on an empty table, pass through dispatch to the final
// state, which loads the result word. Delete, search and list walk the memory
// one record at a time (registered read, then compare) and then load the last
// word; a delete that hits copies each later record down, one read and one
// write per record, so it takes as long as a walk that misses.
// Reset clears the count, sequencer and output valid; the memory is not cleared.
// A stalled output holds the walk; the next command is taken once the last
// word of the current one is in the output register.
// ----------------------------------------------------------------------------
module compacting_record_table import crt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    crt_in_if.sink   i_req,
    crt_out_if.source o_rsp
);

    t_dp_cmd w_ctl;
    t_dp_sts w_sts;
    t_rec    w_in_rec;
    t_rsp    w_out;
    logic    w_out_valid;
    logic    w_req_ready;

    assign w_in_rec.first_low    = i_req.first_low;
    assign w_in_rec.first_high   = i_req.first_high;
    assign w_in_rec.surname_low  = i_req.surname_low;
    assign w_in_rec.surname_high = i_req.surname_high;
    assign w_in_rec.phone_low    = i_req.phone_low;
    assign w_in_rec.phone_high   = i_req.phone_high;

    crt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    crt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_req.cmd),
        .i_rec       (w_in_rec),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_out       (w_out)
    );

    assign i_req.ready = w_req_ready;

    assign o_rsp.valid            = w_out_valid;
    assign o_rsp.status           = w_out.status;
    assign o_rsp.seq_number       = w_out.seq_number;
    assign o_rsp.out_first_low    = w_out.rec.first_low;
    assign o_rsp.out_first_high   = w_out.rec.first_high;
    assign o_rsp.out_surname_low  = w_out.rec.surname_low;
    assign o_rsp.out_surname_high = w_out.rec.surname_high;
    assign o_rsp.out_phone_low    = w_out.rec.phone_low;
    assign o_rsp.out_phone_high   = w_out.rec.phone_high;
    assign o_rsp.last_of_run      = w_out.last_of_run;
    assign o_rsp.record_count     = w_out.record_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid |-> (w_out.record_count <= CNT_W'(TABLE_DEPTH)))
        else $error("record count beyond table depth");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && (w_out.status != ST_OK)) |->
            ((w_out.seq_number == '0) && w_out.last_of_run))
        else $error("status word carries a record or is not last");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && w_req_ready) |=> !w_req_ready)
        else $error("command taken while the previous one is in progress");

    a_record_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.out_load && w_ctl.out_pend) |=> (w_out.seq_number != '0))
        else $error("record word without a sequence number");

endmodule

@@ hdl/crt_datapath.sv @@
// ----------------------------------------------------------------------------
// crt_datapath
// Record memory, captured keys, walk index, record count, pending match
// and the output register.
// ----------------------------------------------------------------------------
module crt_datapath import crt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_rec    i_rec,
    input  t_dp_cmd i_ctl,
    output t_dp_sts o_sts,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_rsp    o_out
);

    t_rec             r_mem [TABLE_DEPTH];
    t_rec             r_rdata;
    t_rec             r_key;
    t_cmd             r_cmd;
    t_rec             r_pend;
    logic [SEQ_W-1:0] r_pend_seq;
    logic             r_pend_valid;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [CNT_W-1:0]  w_idx_prev;
    logic [ADDR_W-1:0] w_wr_addr;
    t_rec              w_wr_data;
    logic              w_first_eq;
    logic              w_surname_eq;
    logic              w_hit;
    logic              w_out_free;
    t_rsp              n_out;

    assign w_idx_prev = r_idx - CNT_W'(1);
    assign w_wr_addr  = i_ctl.wr_add ? r_count[ADDR_W-1:0] : w_idx_prev[ADDR_W-1:0];
    assign w_wr_data  = i_ctl.wr_add ? r_key : r_rdata;

    assign w_first_eq   = (r_rdata.first_low == r_key.first_low) &&
                          (r_rdata.first_high == r_key.first_high);
    assign w_surname_eq = (r_rdata.surname_low == r_key.surname_low) &&
                          (r_rdata.surname_high == r_key.surname_high);

    always_comb begin
        case (r_cmd)
            CMD_DELETE: w_hit = w_first_eq && w_surname_eq;
            CMD_SEARCH: w_hit = w_first_eq;
            CMD_LIST:   w_hit = 1'b1;
            default:    w_hit = 1'b0;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out.last_of_run  = i_ctl.out_last;
        n_out.record_count = r_count;
        if (i_ctl.out_pend) begin
            n_out.status     = ST_OK;
            n_out.seq_number = r_pend_seq;
            n_out.rec        = r_pend;
        end else begin
            n_out.status     = i_ctl.out_status;
            n_out.seq_number = '0;
            n_out.rec        = '0;
        end
    end

    // record memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_add || i_ctl.wr_shift) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_ctl.mem_rd) begin
            r_rdata <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_key <= i_rec;
            r_cmd <= i_cmd;
        end
        if (i_ctl.pend_load) begin
            r_pend <= r_rdata;
        end
        if (i_ctl.out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_pend_seq   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_ctl.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end

            if (i_ctl.capture) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end

            if (i_ctl.capture || i_ctl.pend_clr) begin
                r_pend_valid <= 1'b0;
                r_pend_seq   <= '0;
            end else if (i_ctl.pend_load) begin
                r_pend_valid <= 1'b1;
                r_pend_seq   <= r_pend_seq + SEQ_W'(1);
            end

            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.cmd        = r_cmd;
    assign o_sts.idx_end    = (r_idx == r_count);
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.cnt_full   = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_sts.hit        = w_hit;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.pend_valid = r_pend_valid;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hdl/crt_ctrl.sv @@
// ----------------------------------------------------------------------------
// crt_ctrl
// Command sequencer: dispatches each command, walks the table one record
// at a time (read, then check) and shifts records down after a delete.
// ----------------------------------------------------------------------------
module crt_ctrl import crt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_SH_RD    = 3'd4;
    localparam logic [2:0] S_SH_WR    = 3'd5;
    localparam logic [2:0] S_FLUSH    = 3'd6;
    localparam logic [2:0] S_FINAL    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_status    r_fin_status;
    t_status    n_fin_status;

    always_comb begin
        n_state      = r_state;
        n_fin_status = r_fin_status;
        o_ctl        = '0;
        o_req_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FINAL;
                if (i_sts.cmd == CMD_ADD) begin
                    if (i_sts.cnt_full) begin
                        n_fin_status = ST_FULL;
                    end else begin
                        o_ctl.wr_add  = 1'b1;
                        o_ctl.cnt_inc = 1'b1;
                        n_fin_status  = ST_OK;
                    end
                end else if (i_sts.cnt_zero) begin
                    n_fin_status = ST_EMPTY;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.idx_end) begin
                    if (i_sts.pend_valid) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_fin_status = ST_NOTFOUND;
                        n_state      = S_FINAL;
                    end
                end else begin
                    o_ctl.mem_rd = 1'b1;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_sts.hit) begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end else if (i_sts.cmd == CMD_DELETE) begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_SH_RD;
                end else if (!i_sts.pend_valid) begin
                    o_ctl.pend_load = 1'b1;
                    o_ctl.idx_inc   = 1'b1;
                    n_state         = S_SCAN_RD;
                end else if (i_sts.out_free) begin
                    // a later match exists, so the pending one is not last
                    o_ctl.out_load  = 1'b1;
                    o_ctl.out_pend  = 1'b1;
                    o_ctl.pend_load = 1'b1;
                    o_ctl.idx_inc   = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.idx_end) begin
                    o_ctl.cnt_dec = 1'b1;
                    n_fin_status  = ST_OK;
                    n_state       = S_FINAL;
                end else begin
                    o_ctl.mem_rd = 1'b1;
                    n_state      = S_SH_WR;
                end
            end
            S_SH_WR: begin
                // move the record just read down one slot
                o_ctl.wr_shift = 1'b1;
                o_ctl.idx_inc  = 1'b1;
                n_state        = S_SH_RD;
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_pend = 1'b1;
                    o_ctl.out_last = 1'b1;
                    o_ctl.pend_clr = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load   = 1'b1;
                    o_ctl.out_last   = 1'b1;
                    o_ctl.out_status = r_fin_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fin_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_fin_status <= n_fin_status;
        end
    end

endmodule
